// File: sv/switch_debounce_pulse_relay_latch_assert.svh
// Assertion macros shared by the checker of the switch debounce relay block.
`ifndef SWITCH_DEBOUNCE_PULSE_RELAY_LATCH_ASSERT_SVH
`define SWITCH_DEBOUNCE_PULSE_RELAY_LATCH_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define SDPRL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sdprl assertion failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define SDPRL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sdprl assertion failed");

`endif

// File: sv/sdprl_pkg.sv
// Package with types and constants of the switch debounce relay block.
`default_nettype none

package sdprl_pkg;

  localparam int CHANNELS = 2;

  localparam int DEB_W   = 8;
  localparam int CNT_W   = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_TICKS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_TIME_CAP   = 2'd3;

  // Reset values of the registers and of the press timer.
  localparam logic [DEB_W-1:0] DEBOUNCE_TICKS_RST   = 8'd50;
  localparam logic [CNT_W-1:0] PULSE_TICKS_RST      = 16'd100;
  localparam logic [CNT_W-1:0] LONG_PRESS_TICKS_RST = 16'd500;
  localparam logic [CNT_W-1:0] PRESS_TIME_CAP_RST   = 16'd10000;
  localparam logic [CNT_W-1:0] PRESS_DURATION_RST   = 16'hff;

  // Meaning of the func field.
  localparam logic FUNC_TICK  = 1'b0;
  localparam logic FUNC_EVENT = 1'b1;

  typedef struct packed {
    logic       func;
    logic [1:0] switch_levels;
    logic [1:0] set_levels;
    logic [1:0] reset_levels;
    logic [5:0] changed_pins;
  } in_item_t;

  typedef struct packed {
    logic [1:0] notify_levels;
    logic [1:0] relay_states;
  } out_item_t;

  typedef struct packed {
    logic [DEB_W-1:0] debounce_ticks;
    logic [CNT_W-1:0] pulse_ticks;
    logic [CNT_W-1:0] long_press_ticks;
    logic [CNT_W-1:0] press_time_cap;
  } cfg_t;

  // What one channel sees of the current transaction.
  typedef struct packed {
    logic is_event;
    logic sw_high;
    logic set_high;
    logic rst_high;
    logic sw_edge;
    logic rst_edge;
    logic set_edge;
  } chan_cmd_t;

  // Pin states of one channel after the transaction.
  typedef struct packed {
    logic notify;
    logic relay;
  } chan_out_t;

endpackage

`default_nettype wire

// File: sv/sdprl_cfg.sv
// Configuration register file of the switch debounce relay block.
`default_nettype none

module sdprl_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sdprl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sdprl_pkg::CFG_W-1:0]     cfg_wdata_i,
  output sdprl_pkg::cfg_t                cfg_o
);
  import sdprl_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DEBOUNCE_TICKS:   cfg_d.debounce_ticks   = cfg_wdata_i[DEB_W-1:0];
        REG_PULSE_TICKS:      cfg_d.pulse_ticks      = cfg_wdata_i[CNT_W-1:0];
        REG_LONG_PRESS_TICKS: cfg_d.long_press_ticks = cfg_wdata_i[CNT_W-1:0];
        REG_PRESS_TIME_CAP:   cfg_d.press_time_cap   = cfg_wdata_i[CNT_W-1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks   <= DEBOUNCE_TICKS_RST;
      cfg_q.pulse_ticks      <= PULSE_TICKS_RST;
      cfg_q.long_press_ticks <= LONG_PRESS_TICKS_RST;
      cfg_q.press_time_cap   <= PRESS_TIME_CAP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: sv/sdprl_chan.sv
// State and update logic of one switch, notify and relay channel.
`default_nettype none

module sdprl_chan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  sdprl_pkg::chan_cmd_t cmd_i,
  input  sdprl_pkg::cfg_t      cfg_i,
  output sdprl_pkg::chan_out_t out_o
);
  import sdprl_pkg::*;

  logic [DEB_W-1:0] deb_q, deb_d;
  logic [CNT_W-1:0] pulse_q, pulse_d;
  logic [CNT_W-1:0] press_q, press_d;
  logic             relay_q, relay_d;
  logic             notify_q, notify_d;

  logic             expire;
  logic             start;
  logic [CNT_W-1:0] pulse_mid;
  logic [CNT_W-1:0] press_mid;
  logic             notify_mid;

  always_comb begin
    deb_d    = deb_q;
    pulse_d  = pulse_q;
    press_d  = press_q;
    relay_d  = relay_q;
    notify_d = notify_q;

    // The debounce window closes on the tick that takes the counter from one to zero.
    expire = (deb_q == DEB_W'(1));
    start  = expire && (cmd_i.sw_high
                        ? ((press_q > cfg_i.long_press_ticks) && relay_q)
                        : 1'b1);
    pulse_mid  = start ? cfg_i.pulse_ticks : pulse_q;
    notify_mid = start ? 1'b0 : notify_q;
    press_mid  = (expire && !cmd_i.sw_high) ? '0 : press_q;

    if (cmd_i.is_event) begin
      if (cmd_i.sw_edge) begin
        deb_d = cfg_i.debounce_ticks;
      end
      if (cmd_i.rst_edge && cmd_i.rst_high) begin
        relay_d = 1'b0;
      end
      if (cmd_i.set_edge && cmd_i.set_high && !cmd_i.rst_high) begin
        relay_d = 1'b1;
      end
    end else begin
      if (deb_q != '0) begin
        deb_d = deb_q - DEB_W'(1);
      end
      pulse_d  = pulse_mid;
      notify_d = notify_mid;
      // A pulse started on this tick already loses one count.
      if (pulse_mid != '0) begin
        pulse_d = pulse_mid - CNT_W'(1);
        if (pulse_mid == CNT_W'(1)) begin
          notify_d = 1'b1;
        end
      end
      press_d = press_mid;
      if (!cmd_i.sw_high && (press_mid < cfg_i.press_time_cap)) begin
        press_d = press_mid + CNT_W'(1);
      end
      if (cmd_i.set_high && cmd_i.rst_high) begin
        relay_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q    <= '0;
      pulse_q  <= '0;
      press_q  <= PRESS_DURATION_RST;
      relay_q  <= 1'b0;
      notify_q <= 1'b1;
    end else if (en_i) begin
      deb_q    <= deb_d;
      pulse_q  <= pulse_d;
      press_q  <= press_d;
      relay_q  <= relay_d;
      notify_q <= notify_d;
    end
  end

  assign out_o.notify = notify_d;
  assign out_o.relay  = relay_d;

endmodule

`default_nettype wire

// File: sv/switch_debounce_pulse_relay_latch.sv
// Top level of the two-channel switch debounce, notify pulse and relay latch block.
//
//   channel  | handshake                   | payload
//   ---------+-----------------------------+--------------------------
//   input    | in_valid_i / in_stall_o     | in_data_i  (in_item_t)
//   output   | out_valid_o / out_stall_i   | out_data_o (out_item_t)
//   config   | cfg_we_i (no wait)          | cfg_index_i, cfg_wdata_i
//
// The block takes one transaction per cycle while the output is not stalled; a result
// passes through the input register and then the result register, with the
// per-channel counter update between those two registers.
// Reset sets flags, config and channel state to their documented values; no sweep follows.
// A stall on the output holds the result register and, once the input register is
// also full, raises in_stall_o in the same cycle.
`default_nettype none

module switch_debounce_pulse_relay_latch (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  sdprl_pkg::in_item_t             in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output sdprl_pkg::out_item_t            out_data_o,
  input  logic                            cfg_we_i,
  input  logic [sdprl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [sdprl_pkg::CFG_W-1:0]     cfg_wdata_i
);
  import sdprl_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q, in_valid_d;
  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;
  logic      advance;
  logic      in_take;
  chan_out_t chan_out [CHANNELS];

  sdprl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // The held transaction moves on whenever the result register is empty or drains.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // Each channel updates its counters and pins when the held transaction advances.
  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_chan
    chan_cmd_t cmd;

    assign cmd.is_event = (in_q.func == FUNC_EVENT);
    assign cmd.sw_high  = in_q.switch_levels[ch];
    assign cmd.set_high = in_q.set_levels[ch];
    assign cmd.rst_high = in_q.reset_levels[ch];
    assign cmd.sw_edge  = in_q.changed_pins[ch];
    assign cmd.rst_edge = in_q.changed_pins[CHANNELS + 2 * ch];
    assign cmd.set_edge = in_q.changed_pins[CHANNELS + 2 * ch + 1];

    sdprl_chan u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .cmd_i  (cmd),
      .cfg_i  (cfg),
      .out_o  (chan_out[ch])
    );
  end

  always_comb begin
    out_d = out_q;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      out_d.notify_levels[ch] = chan_out[ch].notify;
      out_d.relay_states[ch]  = chan_out[ch].relay;
    end
    out_valid_d = advance || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: sv/sdprl_checker.sv
// Port-level checker of the switch debounce relay block and its bind.
`default_nettype none
`include "switch_debounce_pulse_relay_latch_assert.svh"

module sdprl_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input sdprl_pkg::out_item_t out_data_o
);

  // A stalled result stays offered and unchanged.
  `SDPRL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `SDPRL_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_data_o))

  // The input side only stalls while a finished result is itself held back.
  `SDPRL_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // An accepted transaction moves from the input register to the output when the output is not stalled.
  `SDPRL_ASSERT_NXT(a_latency, clk_i, rst_ni,
                    (in_valid_i && !in_stall_o) ##1 (!out_valid_o || !out_stall_i), out_valid_o)

endmodule

bind switch_debounce_pulse_relay_latch sdprl_checker u_sdprl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
